FILE: hw/rtl/bdmssm_pkg.sv
`default_nettype none
package bdmssm_pkg;

	localparam int unsigned DATA_BITS_DEF = 32;
	localparam int unsigned CMD_BITS_DEF  = 7;
	localparam int unsigned WORD_W        = 32;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic [1:0] STAT_DATA    = 2'b00;
	localparam logic [1:0] STAT_SEQ_ERR = 2'b01;
	localparam logic [1:0] STAT_IRQ     = 2'b10;

	localparam logic [1:0] RC_OK      = 2'd0;
	localparam logic [1:0] RC_SEQ_ERR = 2'd1;
	localparam logic [1:0] RC_IRQ     = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic              mode_bit;
		logic              control_bit;
		logic [WORD_W-1:0] send_word;
		logic              sampled_dsdo;
	} item_t;

	typedef struct packed {
		logic              drive_dsdi;
		logic              last_bit;
		logic              ready_bit;
		logic [1:0]        target_status;
		logic [WORD_W-1:0] recv_word;
		logic [1:0]        result_code;
	} res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bdmssm_core.sv
`default_nettype none
module bdmssm_core #(
	parameter int unsigned DATA_BITS = bdmssm_pkg::DATA_BITS_DEF,
	parameter int unsigned CMD_BITS  = bdmssm_pkg::CMD_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  bdmssm_pkg::item_t   item,
	output logic                res_valid,
	output bdmssm_pkg::res_t    res
);

	localparam int unsigned MAXB  = (DATA_BITS > CMD_BITS) ? DATA_BITS : CMD_BITS;
	localparam int unsigned PH_W  = $clog2(MAXB + 4);
	localparam int unsigned IDX_W = PH_W + 2;
	localparam logic [PH_W-1:0] LEN_DATA = PH_W'(DATA_BITS);
	localparam logic [PH_W-1:0] LEN_CMD  = PH_W'(CMD_BITS);
	localparam logic [PH_W-1:0] PH_START = PH_W'(0);
	localparam logic [PH_W-1:0] PH_MODE  = PH_W'(1);
	localparam logic [PH_W-1:0] PH_CTRL  = PH_W'(2);
	localparam logic [PH_W-1:0] PH_DATA0 = PH_W'(3);

	logic [PH_W-1:0]                phase_q;
	logic                           busy_q;
	logic [bdmssm_pkg::WORD_W-1:0]  tx_q;
	logic [bdmssm_pkg::WORD_W-1:0]  rx_q;
	logic [PH_W-1:0]                send_len_q;
	logic [1:0]                     prefix_q;
	logic                           ready_q;
	logic [1:0]                     status_q;

	logic [PH_W-1:0]                n;
	logic [PH_W-1:0]                rlen;
	logic [PH_W-1:0]                total;
	logic [IDX_W-1:0]               idx;
	logic                           tx_bit;
	logic                           drive;
	logic                           last;
	logic [1:0]                     status_nx;
	logic [bdmssm_pkg::WORD_W-1:0]  rx_nx;
	logic                           tick;

	assign tick  = step && (item.req_type == bdmssm_pkg::REQ_TICK) && busy_q;
	assign n     = phase_q - PH_DATA0;
	assign rlen  = (status_q == bdmssm_pkg::STAT_DATA) ? LEN_DATA : LEN_CMD;
	assign total = (send_len_q > rlen) ? send_len_q : rlen;
	assign idx   = IDX_W'(send_len_q) - IDX_W'(1) - IDX_W'(n);
	assign tx_bit = (idx[IDX_W-1:5] == '0) ? tx_q[idx[4:0]] : 1'b0;
	assign rx_nx = {rx_q[bdmssm_pkg::WORD_W-2:0], item.sampled_dsdo};

	always_comb begin
		drive     = 1'b0;
		last      = 1'b0;
		status_nx = status_q;
		case (phase_q)
			PH_START: drive = 1'b1;
			PH_MODE: begin
				drive     = prefix_q[1];
				status_nx = {item.sampled_dsdo, 1'b0};
			end
			PH_CTRL: begin
				drive     = prefix_q[0];
				status_nx = {status_q[1], item.sampled_dsdo};
			end
			default: begin
				drive = (n < send_len_q) ? tx_bit : 1'b0;
				last  = ({1'b0, phase_q} >= ({1'b0, total} + (PH_W+1)'(2)));
			end
		endcase
	end

	always_comb begin
		res_valid         = tick;
		res.drive_dsdi    = drive;
		res.last_bit      = last;
		res.ready_bit     = last ? ready_q : 1'b0;
		res.target_status = last ? status_q : 2'b00;
		res.recv_word     = last ? rx_nx : '0;
		case (status_q)
			bdmssm_pkg::STAT_SEQ_ERR: res.result_code = last ? bdmssm_pkg::RC_SEQ_ERR
			                                                 : bdmssm_pkg::RC_OK;
			bdmssm_pkg::STAT_IRQ:     res.result_code = last ? bdmssm_pkg::RC_IRQ
			                                                 : bdmssm_pkg::RC_OK;
			default:                  res.result_code = bdmssm_pkg::RC_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			busy_q     <= 1'b0;
			tx_q       <= '0;
			rx_q       <= '0;
			send_len_q <= LEN_DATA;
			prefix_q   <= '0;
			ready_q    <= 1'b0;
			status_q   <= '0;
		end else if (step && item.req_type == bdmssm_pkg::REQ_START) begin
			prefix_q   <= {item.mode_bit, item.control_bit};
			send_len_q <= item.mode_bit ? LEN_CMD : LEN_DATA;
			tx_q       <= item.send_word;
			rx_q       <= '0;
			ready_q    <= 1'b0;
			status_q   <= '0;
			phase_q    <= '0;
			busy_q     <= 1'b1;
		end else if (tick) begin
			status_q <= status_nx;
			if (phase_q == PH_START)
				ready_q <= item.sampled_dsdo;
			if (phase_q >= PH_DATA0)
				rx_q <= rx_nx;
			if (last) begin
				busy_q  <= 1'b0;
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + PH_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bdm_serial_shift_master.sv
`default_nettype none
// Master side of a background-debug serial transfer. A beat with tuser 0
// (start) loads mode, control and send word and gives no result; each later
// beat with tuser 1 (tick) carries the sampled target output and gives one
// result beat with the data-in level for that clock pulse; tlast marks the
// final tick, where ready, status, received word and result code are valid.
// Ticks while idle are dropped. One beat is taken every cycle unless the input
// stalls; a beat passes an input register, the shift/phase logic and a result
// register on its way to the master side. The input stalls only while the
// result register holds a beat that the master side has not yet accepted.
module bdm_serial_shift_master #(
	parameter int unsigned DATA_BITS = bdmssm_pkg::DATA_BITS_DEF,
	parameter int unsigned CMD_BITS  = bdmssm_pkg::CMD_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [0] mode_bit, [1] control_bit, [33:2] send_word, [34] sampled_dsdo
	input  wire  [39:0] s_tdata,
	// [0] req_type
	input  wire  [0:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [0] drive_dsdi, [1] ready_bit, [3:2] target_status, [35:4] recv_word,
	// [37:36] result_code
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	logic               s1_valid_q;
	bdmssm_pkg::item_t  item_s1;
	logic               stall;
	logic               step;
	logic               res_valid;
	bdmssm_pkg::res_t   res;
	logic               out_valid_q;
	bdmssm_pkg::res_t   out_q;

	assign stall    = out_valid_q && !m_tready;
	assign step     = s1_valid_q && !stall;
	assign s_tready = !s1_valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_tready)
			s1_valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type     <= s_tuser[0];
			item_s1.mode_bit     <= s_tdata[0];
			item_s1.control_bit  <= s_tdata[1];
			item_s1.send_word    <= s_tdata[33:2];
			item_s1.sampled_dsdo <= s_tdata[34];
		end
	end

	bdmssm_core #(
		.DATA_BITS(DATA_BITS),
		.CMD_BITS (CMD_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!stall)
			out_valid_q <= step && res_valid;
	end

	always_ff @(posedge clk) begin
		if (!stall && step && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last_bit;
	assign m_tdata  = {2'b00, out_q.result_code, out_q.recv_word, out_q.target_status,
	                   out_q.ready_bit, out_q.drive_dsdi};

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;

	localparam logic [1:0] STAT_NULL = 2'b11;
	localparam logic [5:0] PH_START = 6'd0;
	localparam logic [5:0] PH_MODE  = 6'd1;
	localparam logic [5:0] PH_CTRL  = 6'd2;
	localparam int unsigned ITEM_TARGET = 1376;
	localparam int unsigned CYCLE_LIMIT = 400000;

	class transfer_tracker;
		logic [5:0]  phase;
		logic        busy;
		logic [31:0] tx_word;
		logic [31:0] rx_word;
		int unsigned send_len;
		logic [1:0]  prefix;
		logic        ready;
		logic [1:0]  status;
		bdmssm_pkg::res_t expected_bits[$];
		int unsigned n_items, n_idle, n_restart, n_checked, errors;
		int unsigned n_done[4];

		function new();
			phase = PH_START;
			busy = 1'b0;
			tx_word = '0;
			rx_word = '0;
			send_len = bdmssm_pkg::DATA_BITS_DEF;
			prefix = '0;
			ready = 1'b0;
			status = bdmssm_pkg::STAT_DATA;
			n_items = 0;
			n_idle = 0;
			n_restart = 0;
			n_checked = 0;
			errors = 0;
			n_done = '{0, 0, 0, 0};
		endfunction

		// predicts the result beat (if any) caused by one accepted input beat
		function void note_beat(logic req, logic mode, logic ctrl, logic [31:0] word,
				logic dsdo);
			bdmssm_pkg::res_t r;
			int unsigned n, rlen, total;
			r = '0;
			if (req == bdmssm_pkg::REQ_START) begin
				n_items++;
				if (busy)
					n_restart++;
				prefix = {mode, ctrl};
				send_len = mode ? bdmssm_pkg::CMD_BITS_DEF : bdmssm_pkg::DATA_BITS_DEF;
				tx_word = word;
				rx_word = '0;
				ready = 1'b0;
				status = bdmssm_pkg::STAT_DATA;
				phase = PH_START;
				busy = 1'b1;
				return;
			end
			if (!busy) begin
				n_idle++;
				return;
			end
			n_items++;
			case (phase)
				PH_START: begin
					r.drive_dsdi = 1'b1;
					ready = dsdo;
				end
				PH_MODE: begin
					r.drive_dsdi = prefix[1];
					status = {dsdo, 1'b0};
				end
				PH_CTRL: begin
					r.drive_dsdi = prefix[0];
					status[0] = dsdo;
				end
				default: begin
					n = phase - 3;
					rlen = (status == bdmssm_pkg::STAT_DATA) ? bdmssm_pkg::DATA_BITS_DEF
					                                         : bdmssm_pkg::CMD_BITS_DEF;
					total = (send_len > rlen) ? send_len : rlen;
					if (n < send_len)
						r.drive_dsdi = tx_word[send_len - 1 - n];
					rx_word = {rx_word[30:0], dsdo};
					r.last_bit = (n + 1 >= total);
				end
			endcase
			if (r.last_bit) begin
				r.ready_bit = ready;
				r.target_status = status;
				r.recv_word = rx_word;
				case (status)
					bdmssm_pkg::STAT_SEQ_ERR: r.result_code = bdmssm_pkg::RC_SEQ_ERR;
					bdmssm_pkg::STAT_IRQ:     r.result_code = bdmssm_pkg::RC_IRQ;
					default:                  r.result_code = bdmssm_pkg::RC_OK;
				endcase
				n_done[status]++;
				busy = 1'b0;
				phase = PH_START;
			end else begin
				phase = phase + 6'd1;
			end
			expected_bits.push_back(r);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(logic [39:0] data, logic last);
			bdmssm_pkg::res_t e;
			n_checked++;
			if (expected_bits.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got data %h last %b",
					$time, data, last);
				errors++;
				return;
			end
			e = expected_bits.pop_front();
			compare("drive_dsdi", 32'(e.drive_dsdi), 32'(data[0]));
			compare("last_bit", 32'(e.last_bit), 32'(last));
			compare("ready_bit", 32'(e.ready_bit), 32'(data[1]));
			compare("target_status", 32'(e.target_status), 32'(data[3:2]));
			compare("recv_word", e.recv_word, data[35:4]);
			compare("result_code", 32'(e.result_code), 32'(data[37:36]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	transfer_tracker sb = new();
	int unsigned cycles = 0;
	bit held_off = 1'b0;

	bdm_serial_shift_master DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// entered and left at a falling edge
	task send_beat(logic req, logic mode, logic ctrl, logic [31:0] word, logic dsdo);
		int unsigned gap;
		gap = (sb.n_items % 200 < 40) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {5'b0, dsdo, word, ctrl, mode};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(req, mode, ctrl, word, dsdo);
		@(negedge clk);
	endtask

	// level < 0 gives random samples
	task ticks_while_busy(int unsigned limit, int level);
		int unsigned k;
		k = 0;
		while (sb.busy && k < limit) begin
			send_beat(bdmssm_pkg::REQ_TICK, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom,
				(level < 0) ? 1'($urandom_range(0, 1)) : level[0]);
			k++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = bdmssm_pkg::REQ_START;
		s_tdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// tick with no transfer running
		send_beat(bdmssm_pkg::REQ_TICK, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
		// command mode, null status, all ones
		send_beat(bdmssm_pkg::REQ_START, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
		ticks_while_busy(100, 1);
		// data-mode transfer, cut short by the restart below
		send_beat(bdmssm_pkg::REQ_START, 1'b0, 1'b0, 32'h0000_0000, 1'b1);
		ticks_while_busy(2, 0);
		// restart while running: command mode, core interrupt status
		send_beat(bdmssm_pkg::REQ_START, 1'b1, 1'b0, 32'h0000_0000, 1'b0);
		send_beat(bdmssm_pkg::REQ_TICK, 1'b0, 1'b0, 32'h0, 1'b0);
		send_beat(bdmssm_pkg::REQ_TICK, 1'b0, 1'b0, 32'h0, 1'b1);
		send_beat(bdmssm_pkg::REQ_TICK, 1'b0, 1'b0, 32'h0, 1'b0);
		ticks_while_busy(100, -1);

		while (sb.n_items < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(bdmssm_pkg::REQ_TICK, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
			send_beat(bdmssm_pkg::REQ_START, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
			ticks_while_busy(($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : 100, -1);
		end
		s_tvalid = 1'b0;

		while (sb.expected_bits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.expected_bits.size() != 0) begin
			$display("%0t: %0d result beats never arrived", $time, sb.expected_bits.size());
			sb.errors++;
		end

		$display("%0d beats taken, %0d idle ticks dropped, %0d restarts, %0d results checked",
			sb.n_items, sb.n_idle, sb.n_restart, sb.n_checked);
		$display("transfers done by status 00/01/10/11: %0d/%0d/%0d/%0d",
			sb.n_done[bdmssm_pkg::STAT_DATA], sb.n_done[bdmssm_pkg::STAT_SEQ_ERR],
			sb.n_done[bdmssm_pkg::STAT_IRQ], sb.n_done[STAT_NULL]);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			// long hold-off so the block backs up and stalls its input
			if (!held_off && sb.n_items > 500) begin
				held_off = 1'b1;
				m_tready = 1'b0;
				repeat (300) @(negedge clk);
			end
			gap = (sb.n_checked % 250 < 50) ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_beat(m_tdata, m_tlast);
			@(negedge clk);
		end
	end

endmodule

FILE: bdm_serial_shift_master.f
hw/rtl/bdmssm_pkg.sv
hw/rtl/bdmssm_core.sv
hw/rtl/bdm_serial_shift_master.sv
tb/sv/testbench.sv
